### hdl/tvtcs_pkg.sv
// Shared constants, types, sine table and microcode for the three-voice chord synth.
`default_nettype none

package tvtcs_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int VOICES          = 3;

  localparam int QUARTER   = 1 << (SINE_TABLE_BITS - 2);
  localparam int HOLD_W    = 22;
  localparam int RATIO_W   = 16;
  localparam int PHASE_W   = 32;
  localparam int SAMPLE_W  = 16;
  localparam int FACTOR_W  = 17;
  localparam int CFG_IDX_W = 3;

  localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int ACC_W   = 32 + $clog2(VOICES);
  localparam int MUL_A_W = ACC_W + 1;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
  localparam int MIX_GAIN_Q15 = 9830;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [FACTOR_W-1:0] LFO_FACTOR [3] = '{17'd65536, 17'd68157, 17'd71434};

  localparam logic [HOLD_W-1:0]  HOLD_RESET     = 22'd4410;
  localparam logic [RATIO_W-1:0] RATIO_RESET [3] = '{16'd4096, 16'd6144, 16'd8192};
  localparam logic [PHASE_W-1:0] LFO_STEP_RESET = 32'd48695;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_SAMPLES = 3'd0,
    REG_RATIO_LOW    = 3'd1,
    REG_RATIO_MID    = 3'd2,
    REG_RATIO_HIGH   = 3'd3,
    REG_LFO_STEP     = 3'd4
  } reg_index_t;

  typedef logic [14:0] qsine_t [QUARTER+1];

  function automatic longint unsigned long_div(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  function automatic logic [14:0] sine_q15_of(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned n;
    longint sum;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (n = 1; n <= 8; n++) begin
      term = long_div((term * x2) >> 30, (2 * n) * (2 * n + 1));
      if (n[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) sum = 32767;
    return sum[14:0];
  endfunction

  function automatic qsine_t build_qsine();
    qsine_t t;
    for (int i = 0; i <= QUARTER; i++) begin
      t[i] = sine_q15_of((longint'(i) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2));
    end
    return t;
  endfunction

  localparam qsine_t QSINE = build_qsine();

  // Microcode
  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_STEP_MUL,
    OP_STEP_WR,
    OP_TONE_SINE,
    OP_LFO_SINE,
    OP_PROD_MUL,
    OP_ACCUM,
    OP_GAIN_MUL,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    CND_NEXT,
    CND_ALWAYS,
    CND_NO_ITEM,
    CND_NO_LATCH,
    CND_MORE_VOICES,
    CND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  localparam logic [PC_W-1:0] PC_TAKE      = 4'd0;
  localparam logic [PC_W-1:0] PC_LATCH_CHK = 4'd1;
  localparam logic [PC_W-1:0] PC_STEP_MUL  = 4'd2;
  localparam logic [PC_W-1:0] PC_STEP_WR   = 4'd3;
  localparam logic [PC_W-1:0] PC_TONE_SINE = 4'd4;
  localparam logic [PC_W-1:0] PC_LFO_SINE  = 4'd5;
  localparam logic [PC_W-1:0] PC_PROD_MUL  = 4'd6;
  localparam logic [PC_W-1:0] PC_ACCUM     = 4'd7;
  localparam logic [PC_W-1:0] PC_GAIN_MUL  = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT      = 4'd9;
  localparam logic [PC_W-1:0] PC_LOOP      = 4'd10;

  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      PC_TAKE:      w = '{OP_TAKE,      CND_NO_ITEM,     PC_TAKE};
      PC_LATCH_CHK: w = '{OP_NONE,      CND_NO_LATCH,    PC_TONE_SINE};
      PC_STEP_MUL:  w = '{OP_STEP_MUL,  CND_NEXT,        PC_TAKE};
      PC_STEP_WR:   w = '{OP_STEP_WR,   CND_MORE_VOICES, PC_STEP_MUL};
      PC_TONE_SINE: w = '{OP_TONE_SINE, CND_NEXT,        PC_TAKE};
      PC_LFO_SINE:  w = '{OP_LFO_SINE,  CND_NEXT,        PC_TAKE};
      PC_PROD_MUL:  w = '{OP_PROD_MUL,  CND_NEXT,        PC_TAKE};
      PC_ACCUM:     w = '{OP_ACCUM,     CND_MORE_VOICES, PC_TONE_SINE};
      PC_GAIN_MUL:  w = '{OP_GAIN_MUL,  CND_NEXT,        PC_TAKE};
      PC_EMIT:      w = '{OP_EMIT,      CND_OUT_BUSY,    PC_EMIT};
      PC_LOOP:      w = '{OP_NONE,      CND_ALWAYS,      PC_TAKE};
      default:      w = '{OP_NONE,      CND_ALWAYS,      PC_TAKE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hdl/three_voice_tremolo_chord_synth.sv
// Top level: microcoded three-voice sine chord synth with per-voice tremolo.
// Each taken note step yields one sample_out word, registered at the emit step; a tick
// that latches a new note step first recomputes the per-voice tone steps.
// A new note step is taken only after the word is emitted, as the microcode steps the
// single shared multiplier and sine table once per microcode word.
// Reset: registers take their default values, phases, steps and hold count clear.
`default_nettype none

module three_voice_tremolo_chord_synth import tvtcs_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [PHASE_W-1:0]          note_step,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [SAMPLE_W-1:0]       sample_out,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [PHASE_W-1:0]          cfg_data
);

  logic [HOLD_W-1:0]  hold_samples;
  logic [RATIO_W-1:0] ratio [3];
  logic [PHASE_W-1:0] lfo_step;

  logic [HOLD_W-1:0]  hold_count;
  logic [PHASE_W-1:0] tone_phase [VOICES];
  logic [PHASE_W-1:0] tone_step  [VOICES];
  logic [PHASE_W-1:0] lfo_phase  [VOICES];

  logic [PC_W-1:0]    pc, pc_next;
  logic [VOICE_W-1:0] v;
  logic [1:0]         r3;
  logic               latch;
  logic [PHASE_W-1:0] note;
  logic [PHASE_W-1:0] lstep;
  logic signed [SAMPLE_W-1:0] s, t;
  logic signed [ACC_W-1:0]    acc;
  logic signed [PROD_W-1:0]   prod;

  uword_t uw;
  logic take, last_voice, out_busy, jump;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [PHASE_W-1:0] sine_phase;
  logic signed [SAMPLE_W-1:0] sine_val;
  logic signed [PROD_W-1:0] rnd, q;
  logic signed [SAMPLE_W-1:0] sat;

  function automatic logic signed [SAMPLE_W-1:0] sine_of(logic [PHASE_W-1:0] phase);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS-3:0] pos;
    logic [SINE_TABLE_BITS-2:0] mirror;
    logic [14:0] mag;
    idx = phase[PHASE_W-1 -: SINE_TABLE_BITS];
    pos = idx[SINE_TABLE_BITS-3:0];
    mirror = (SINE_TABLE_BITS-1)'(QUARTER) - {1'b0, pos};
    mag = idx[SINE_TABLE_BITS-2] ? QSINE[mirror] : QSINE[{1'b0, pos}];
    return idx[SINE_TABLE_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  assign uw         = ucode(pc);
  assign in_stall   = (uw.op != OP_TAKE);
  assign take       = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign last_voice = (v == VOICE_W'(VOICES - 1));
  assign out_busy   = out_valid && out_stall;

  always_comb begin
    case (uw.cond)
      CND_NEXT:        jump = 1'b0;
      CND_ALWAYS:      jump = 1'b1;
      CND_NO_ITEM:     jump = !in_valid;
      CND_NO_LATCH:    jump = !latch;
      CND_MORE_VOICES: jump = !last_voice;
      CND_OUT_BUSY:    jump = out_busy;
      default:         jump = 1'b1;
    endcase
    pc_next = jump ? uw.target : pc + PC_W'(1);
  end

  always_comb begin
    sine_phase = (uw.op == OP_LFO_SINE) ? lfo_phase[v] : tone_phase[v];
    sine_val   = sine_of(sine_phase);
  end

  always_comb begin
    case (uw.op)
      OP_STEP_MUL: begin
        mul_a = $signed({{(MUL_A_W-PHASE_W){1'b0}}, note});
        mul_b = $signed({{(MUL_B_W-RATIO_W){1'b0}}, ratio[r3]});
      end
      OP_TONE_SINE: begin
        mul_a = $signed({{(MUL_A_W-PHASE_W){1'b0}}, lfo_step});
        mul_b = $signed({{(MUL_B_W-FACTOR_W){1'b0}}, LFO_FACTOR[r3]});
      end
      OP_PROD_MUL: begin
        mul_a = {{(MUL_A_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
        mul_b = {{(MUL_B_W-SAMPLE_W){t[SAMPLE_W-1]}}, t};
      end
      OP_GAIN_MUL: begin
        mul_a = {acc[ACC_W-1], acc};
        mul_b = MUL_B_W'(MIX_GAIN_Q15);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    rnd = prod + (PROD_W'(1) <<< 29);
    q   = rnd >>> 30;
    if (q > PROD_W'(32767)) sat = 16'sh7FFF;
    else if (q < -PROD_W'(32768)) sat = -16'sh8000;
    else sat = q[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_samples <= HOLD_RESET;
      ratio        <= RATIO_RESET;
      lfo_step     <= LFO_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOLD_SAMPLES: hold_samples <= cfg_data[HOLD_W-1:0];
        REG_RATIO_LOW:    ratio[0] <= cfg_data[RATIO_W-1:0];
        REG_RATIO_MID:    ratio[1] <= cfg_data[RATIO_W-1:0];
        REG_RATIO_HIGH:   ratio[2] <= cfg_data[RATIO_W-1:0];
        REG_LFO_STEP:     lfo_step <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pc <= PC_TAKE;
    else pc <= pc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= '0;
      latch      <= 1'b0;
      v          <= '0;
      r3         <= '0;
      acc        <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        tone_phase[i] <= '0;
        tone_step[i]  <= '0;
        lfo_phase[i]  <= '0;
      end
    end else begin
      if (uw.op == OP_EMIT && !out_busy) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (uw.op)
        OP_TAKE: begin
          if (take) begin
            latch <= (hold_count > hold_samples);
            acc   <= '0;
            if (hold_count > hold_samples) hold_count <= HOLD_W'(1);
            else if (hold_count != HOLD_MAX) hold_count <= hold_count + HOLD_W'(1);
          end
        end
        OP_STEP_WR: begin
          tone_step[v] <= prod[12 +: PHASE_W];
        end
        OP_ACCUM: begin
          acc <= acc + prod[ACC_W-1:0];
          tone_phase[v] <= tone_phase[v] + tone_step[v];
          lfo_phase[v]  <= lfo_phase[v] + lstep;
        end
        default: ;
      endcase
      if (uw.op == OP_STEP_WR || uw.op == OP_ACCUM) begin
        v  <= last_voice ? '0 : v + VOICE_W'(1);
        r3 <= (last_voice || r3 == 2'd2) ? 2'd0 : r3 + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      OP_TAKE:      if (take) note <= note_step;
      OP_TONE_SINE: s <= sine_val;
      OP_LFO_SINE: begin
        t     <= sine_val;
        lstep <= prod[16 +: PHASE_W];
      end
      OP_EMIT:      if (!out_busy) sample_out <= sat;
      default: ;
    endcase
    if (uw.op == OP_STEP_MUL || uw.op == OP_TONE_SINE || uw.op == OP_PROD_MUL ||
        uw.op == OP_GAIN_MUL) begin
      prod <= mul_a * mul_b;
    end
  end

  a_latch_decision: assert property (@(posedge clk) disable iff (rst)
    take |=> latch == ($past(hold_count) > $past(hold_samples)))
    else $error("latch decision does not match hold count");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    take |=> acc == '0)
    else $error("accumulator not cleared on new word");

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pc) == PC_EMIT)
    else $error("output word raised outside the emit step");

  a_voice_range: assert property (@(posedge clk) disable iff (rst)
    v <= VOICE_W'(VOICES - 1))
    else $error("voice counter out of range");

  a_voice_wrapped: assert property (@(posedge clk) disable iff (rst)
    pc == PC_TAKE |-> (v == '0 && r3 == 2'd0))
    else $error("voice counters not wrapped at word start");

endmodule

`default_nettype wire

### sim/chord_sample_checker.sv
// Checker for the chord synth: predicts each sample word and compares it on the output channel.
module chord_sample_checker import tvtcs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [PHASE_W-1:0]         note_step,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] sample_out,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [PHASE_W-1:0]         cfg_data,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_BITS   = 10;
  localparam int QTR        = 1 << (TBL_BITS - 2);
  localparam int NUM_VOICES = 3;
  localparam longint GAIN_Q15 = 9830;
  localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;
  localparam logic [16:0] TREM_FACTOR [3] = '{17'd65536, 17'd68157, 17'd71434};
  localparam logic [HOLD_W-1:0] COUNT_CEIL = '1;

  int qsin [QTR+1];

  logic [HOLD_W-1:0]  held_ticks;
  logic [HOLD_W-1:0]  hold_limit;
  logic [RATIO_W-1:0] voice_ratio [NUM_VOICES];
  logic [PHASE_W-1:0] trem_step;
  logic [PHASE_W-1:0] tone_ph  [NUM_VOICES];
  logic [PHASE_W-1:0] tone_inc [NUM_VOICES];
  logic [PHASE_W-1:0] trem_ph  [NUM_VOICES];

  logic signed [SAMPLE_W-1:0] expected_samples [$];
  logic signed [SAMPLE_W-1:0] want;
  int errs = 0;

  function automatic int taylor_sine_q15(longint unsigned ang);
    longint unsigned sq;
    longint unsigned t;
    longint acc;
    sq = (ang * ang) >> 30;
    t = ang;
    acc = longint'(ang);
    for (int k = 1; k <= 8; k++) begin
      t = ((t * sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 16384) / 32768;
    if (acc > 32767) acc = 32767;
    return int'(acc);
  endfunction

  initial begin
    for (int i = 0; i <= QTR; i++) begin
      qsin[i] = taylor_sine_q15((64'(i) * RIGHT_ANGLE_Q30) / 64'(QTR));
    end
  end

  function automatic int wave(logic [PHASE_W-1:0] ph);
    logic [TBL_BITS-1:0] idx;
    int mag;
    idx = ph[PHASE_W-1 -: TBL_BITS];
    if (idx[TBL_BITS-2]) mag = qsin[QTR - int'(idx[TBL_BITS-3:0])];
    else mag = qsin[int'(idx[TBL_BITS-3:0])];
    return idx[TBL_BITS-1] ? -mag : mag;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] next_sample(logic [PHASE_W-1:0] note);
    longint mix;
    longint q;
    logic [63:0] prod;
    if (held_ticks > hold_limit) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        prod = 64'(note) * 64'(voice_ratio[v]);
        tone_inc[v] = prod[43:12];
      end
      held_ticks = '0;
    end
    mix = 0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      mix = mix + longint'(wave(tone_ph[v])) * longint'(wave(trem_ph[v]));
      prod = 64'(trem_step) * 64'(TREM_FACTOR[v]);
      tone_ph[v] = tone_ph[v] + tone_inc[v];
      trem_ph[v] = trem_ph[v] + prod[47:16];
    end
    q = (mix * GAIN_Q15 + (longint'(1) << 29)) >>> 30;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    if (held_ticks != COUNT_CEIL) held_ticks = held_ticks + 1'b1;
    return q[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_ticks = '0;
      hold_limit = 22'd4410;
      voice_ratio = '{16'd4096, 16'd6144, 16'd8192};
      trem_step = 32'd48695;
      for (int v = 0; v < NUM_VOICES; v++) begin
        tone_ph[v] = '0;
        tone_inc[v] = '0;
        trem_ph[v] = '0;
      end
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HOLD_SAMPLES: hold_limit = cfg_data[HOLD_W-1:0];
          REG_RATIO_LOW:    voice_ratio[0] = cfg_data[RATIO_W-1:0];
          REG_RATIO_MID:    voice_ratio[1] = cfg_data[RATIO_W-1:0];
          REG_RATIO_HIGH:   voice_ratio[2] = cfg_data[RATIO_W-1:0];
          REG_LFO_STEP:     trem_step = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_samples.insert(expected_samples.size(), next_sample(note_step));
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out: unexpected word, expected none, got %0d", sample_out);
          errs++;
        end else begin
          want = expected_samples.pop_front();
          if (want !== sample_out) begin
            $error("sample_out mismatch: expected %0d, got %0d", want, sample_out);
            errs++;
          end
        end
      end
    end
    pending <= expected_samples.size();
    fail_count <= errs;
  end

endmodule

### sim/tb_three_voice_tremolo_chord_synth.sv
// Testbench top for the chord synth: stimulus, receiver stalls, watchdog and verdict.
module tb_three_voice_tremolo_chord_synth import tvtcs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_NOTES     = 950;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_LIMIT      = 4000;
  localparam int DRAIN_CYCLES    = 40;
  localparam logic [PHASE_W-1:0] EDGE_NOTES [9] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h4000_0000, 32'h0100_0000, 32'h0AAA_AAAA, 32'h5555_5555
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [PHASE_W-1:0]         note_step = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [PHASE_W-1:0]         cfg_data = '0;

  int   fail_count;
  int   pending;
  logic hold_off_go = 1'b0;
  logic hold_off_ack = 1'b0;
  int   idle_cycles = 0;
  int   notes_sent = 0;
  int   burst_left = 0;

  three_voice_tremolo_chord_synth dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .note_step(note_step),
    .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  chord_sample_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .note_step(note_step),
    .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_three_voice_tremolo_chord_synth: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int span;
    int pct;
    forever begin
      span = $urandom_range(10, 120);
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 25;
        2: pct = 60;
        default: pct = 90;
      endcase
      repeat (span) begin
        @(posedge clk);
        if (hold_off_go != hold_off_ack) begin
          hold_off_ack = hold_off_go;
          out_stall <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
        end
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PHASE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_note(input logic [PHASE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    note_step <= value;
    do @(posedge clk); while (in_stall);
    burst_left--;
    notes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [PHASE_W-1:0] random_note();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      2, 3, 4: return $urandom_range(0, 1 << 26);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [RATIO_W-1:0] random_ratio();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return RATIO_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic pick_setup();
    logic [HOLD_W-1:0]  hold;
    logic [PHASE_W-1:0] junk;
    logic [PHASE_W-1:0] lfo;
    case ($urandom_range(0, 6))
      0: hold = '0;
      1: hold = HOLD_W'(1);
      2: hold = HOLD_W'($urandom_range(0, 15));
      3: hold = HOLD_W'($urandom_range(16, 200));
      4: hold = 22'd4410;
      5: hold = HOLD_MAX;
      default: hold = HOLD_W'($urandom());
    endcase
    case ($urandom_range(0, 4))
      0: lfo = '0;
      1: lfo = '1;
      2: lfo = $urandom_range(0, 1 << 20);
      default: lfo = $urandom();
    endcase
    junk = $urandom();
    write_reg(REG_HOLD_SAMPLES, {junk[PHASE_W-1:HOLD_W], hold});
    write_reg(REG_RATIO_LOW, {junk[PHASE_W-1:RATIO_W], random_ratio()});
    write_reg(REG_RATIO_MID, {junk[RATIO_W-1:0], random_ratio()});
    write_reg(REG_RATIO_HIGH, {~junk[PHASE_W-1:RATIO_W], random_ratio()});
    write_reg(REG_LFO_STEP, lfo);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_LFO_STEP + 1, (1 << CFG_IDX_W) - 1)), $urandom());
    end
  endtask

  initial begin
    int phase_len;
    int phase_no;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_HOLD_SAMPLES, '0);
    write_reg(REG_RATIO_LOW, 32'd4096);
    write_reg(REG_RATIO_MID, 32'd6144);
    write_reg(REG_RATIO_HIGH, 32'd8192);
    write_reg(REG_LFO_STEP, 32'h0123_4567);
    foreach (EDGE_NOTES[i]) send_note(EDGE_NOTES[i]);
    settle();

    write_reg(REG_RATIO_LOW, '1);
    write_reg(REG_RATIO_MID, '1);
    write_reg(REG_RATIO_HIGH, '1);
    write_reg(REG_LFO_STEP, '1);
    send_note('1);
    send_note(32'h1234_5678);
    send_note(32'h8000_0000);
    settle();

    for (int i = REG_LFO_STEP + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), '0);
    end
    send_note(32'h0300_0000);
    send_note(32'hC000_0001);
    settle();

    write_reg(REG_RATIO_LOW, 32'hFFFF_0000);
    write_reg(REG_RATIO_MID, 32'hFFFF_0000);
    write_reg(REG_RATIO_HIGH, 32'hFFFF_0000);
    write_reg(REG_LFO_STEP, '0);
    send_note(32'h2000_0000);
    send_note('1);
    settle();

    write_reg(REG_HOLD_SAMPLES, '1);
    write_reg(REG_RATIO_LOW, 32'd4096);
    write_reg(REG_RATIO_MID, 32'd6144);
    write_reg(REG_RATIO_HIGH, 32'd8192);
    write_reg(REG_LFO_STEP, 32'h0010_0000);
    repeat (4) send_note(random_note());
    settle();

    write_reg(REG_HOLD_SAMPLES, 32'd2);
    repeat (6) send_note(32'h0080_0000 + notes_sent);
    settle();

    phase_no = 0;
    while (notes_sent < TOTAL_NOTES) begin
      pick_setup();
      if (phase_no % 5 == 0) hold_off_go <= ~hold_off_go;
      phase_len = $urandom_range(40, 110);
      repeat (phase_len) send_note(random_note());
      settle();
      phase_no++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_three_voice_tremolo_chord_synth: PASS");
    end else begin
      $display("tb_three_voice_tremolo_chord_synth: FAIL");
    end
    $finish;
  end

endmodule

### three_voice_tremolo_chord_synth.f
hdl/tvtcs_pkg.sv
hdl/three_voice_tremolo_chord_synth.sv
sim/chord_sample_checker.sv
sim/tb_three_voice_tremolo_chord_synth.sv
